/* sv/assert_macros.svh */
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define BLE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define BLE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ble_pkg.sv */
// types and constants of the bounded list engine
package ble_pkg;

  localparam int MODE_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 5;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    M_PUSH     = 4'd0,
    M_POP      = 4'd1,
    M_PEEK     = 4'd2,
    M_GET      = 4'd3,
    M_SET      = 4'd4,
    M_INSERT   = 4'd5,
    M_REMOVE   = 4'd6,
    M_FAST_REM = 4'd7,
    M_CONTAINS = 4'd8,
    M_REVERSE  = 4'd9,
    M_CLEAR    = 4'd10,
    M_RESIZE   = 4'd11
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_BADIDX  = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_INS_RD,
    S_INS_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHF_RD,
    S_SHF_WR,
    S_FAST_WR,
    S_REV_RDLO,
    S_REV_RDHI,
    S_REV_WRLO,
    S_REV_WRHI,
    S_DONE
  } state_t;

endpackage

/* sv/ble_ifs.sv */
// valid/ready channels of the bounded list engine
interface ble_in_if;
  import ble_pkg::*;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;
  logic [INDEX_W-1:0] index;
  modport source (output valid, mode, value, index, input ready);
  modport sink   (input valid, mode, value, index, output ready);
endinterface

interface ble_out_if;
  import ble_pkg::*;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  result_value;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  item_count;
  modport source (output valid, result_value, status, item_count, input ready);
  modport sink   (input valid, result_value, status, item_count, output ready);
endinterface

/* sv/ble_ram.sv */
// generic single write port ram with one registered read port
module ble_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/bounded_list_engine_unit.sv */
// top level of the bounded list engine: sequencer, list store and result register
//
// A fixed-capacity ordered list of DEPTH words of ITEM_WIDTH bits. Each beat on
// in_bus carries mode, value and index and selects one of twelve list operations;
// each yields exactly one beat on out_bus with result_value, status and item_count.
// Both channels are valid/ready; a beat moves when valid and ready are both high.
// in_bus.ready is high only while the sequencer is idle: one operation at a time.
// Push, set, clear, resize and any rejected operation finish in the dispatch step;
// pop, peek and get add one registered read of the store. Search walks the list
// with a read and a compare step per entry; ordered remove and insert shift
// entries with a read and a write step per moved entry; reverse reads both ends
// and writes both ends of each swapped pair. The single ram port pair (one write,
// one registered read) and the one pointer adder force these steps to run in turn.
// The next input beat is taken in the cycle after the result is loaded into the
// output register.
// After reset the store is zeroed by a pass over all DEPTH entries, one entry a cycle,
// during which no input beat is taken; the count resets to zero.
// The result sits in an output register; while the receiver stalls it holds, the
// next input beat may still be taken, and its result waits until the register frees.
`include "assert_macros.svh"

module bounded_list_engine_unit #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ble_in_if.sink    in_bus,
  ble_out_if.source out_bus
);
  import ble_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [CW-1:0] PTR_LAST = CW'(DEPTH - 1);
  localparam logic [XW-1:0] DEPTH_X  = XW'(DEPTH);

  state_t                state_r, state_nxt;
  mode_t                 op_r;
  logic [ITEM_WIDTH-1:0] val_r;
  logic [INDEX_W-1:0]    idx_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         hi_r, hi_nxt;
  logic [ITEM_WIDTH-1:0] tmp_r, tmp_nxt;
  logic [VALUE_W-1:0]    res_value_r, res_value_nxt;
  status_t               res_status_r, res_status_nxt;
  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_value_r;
  status_t               out_status_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;

  // shared pointer adder
  logic                  alu_hi, alu_dec;
  logic [CW-1:0]         alu_a, alu_y;

  logic                  in_acc, out_load;
  logic                  full, empty, hit;
  logic [CW-1:0]         cnt_dec;
  logic [XW-1:0]         idx_x, cnt_x;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);
  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign hit      = (ram_rdata == val_r);
  assign cnt_dec  = cnt_r - CW'(1);
  assign idx_x    = XW'(idx_r);
  assign cnt_x    = XW'(cnt_r);
  assign alu_a    = alu_hi ? CW'(hi_r) : ptr_r;
  assign alu_y    = alu_a + (alu_dec ? '1 : CW'(1));

  ble_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (ptr_r == PTR_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (op_r) inside
          M_POP, M_PEEK: state_nxt = empty ? S_DONE : S_READ;
          M_GET:         state_nxt = (idx_x >= cnt_x) ? S_DONE : S_READ;
          M_INSERT:      state_nxt = (full || idx_x > cnt_x) ? S_DONE : S_INS_RD;
          M_REMOVE, M_FAST_REM, M_CONTAINS:
                         state_nxt = empty ? S_DONE : S_SRCH_RD;
          M_REVERSE:     state_nxt = (cnt_r > CW'(1)) ? S_REV_RDLO : S_DONE;
          default:       state_nxt = S_DONE;
        endcase
      end
      S_READ:   state_nxt = S_DONE;
      S_INS_RD: state_nxt = (ptr_r == CW'(idx_x)) ? S_DONE : S_INS_WR;
      S_INS_WR: state_nxt = S_INS_RD;
      S_SRCH_RD: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (hit) begin
          if (op_r == M_REMOVE) begin
            state_nxt = S_SHF_RD;
          end else if (op_r == M_FAST_REM && ptr_r != cnt_dec) begin
            state_nxt = S_FAST_WR;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = (alu_y == cnt_r) ? S_DONE : S_SRCH_RD;
        end
      end
      S_SHF_RD:   state_nxt = (alu_y >= cnt_r) ? S_DONE : S_SHF_WR;
      S_SHF_WR:   state_nxt = S_SHF_RD;
      S_FAST_WR:  state_nxt = S_DONE;
      S_REV_RDLO: state_nxt = (ptr_r >= CW'(hi_r)) ? S_DONE : S_REV_RDHI;
      S_REV_RDHI: state_nxt = S_REV_WRLO;
      S_REV_WRLO: state_nxt = S_REV_WRHI;
      S_REV_WRHI: state_nxt = S_REV_RDLO;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    hi_nxt         = hi_r;
    tmp_nxt        = tmp_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = ptr_r[AW-1:0];
    alu_hi         = 1'b0;
    alu_dec        = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ptr_nxt   = (ptr_r == PTR_LAST) ? '0 : alu_y;
      end
      S_DISPATCH: begin
        res_value_nxt  = '0;
        res_status_nxt = ST_OK;
        unique case (op_r) inside
          M_PUSH: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_r[AW-1:0];
              ram_wdata = val_r;
              cnt_nxt   = cnt_r + CW'(1);
            end
          end
          M_POP, M_PEEK: begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = cnt_dec[AW-1:0];
            end
          end
          M_GET: begin
            if (idx_x >= cnt_x) begin
              res_status_nxt = ST_BADIDX;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'(idx_x);
            end
          end
          M_SET: begin
            if (idx_x >= DEPTH_X) begin
              res_status_nxt = ST_BADIDX;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(idx_x);
              ram_wdata = val_r;
              if (idx_x >= cnt_x) cnt_nxt = CW'(idx_x + XW'(1));
            end
          end
          M_INSERT: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else if (idx_x > cnt_x) begin
              res_status_nxt = ST_BADIDX;
            end else begin
              ptr_nxt = cnt_r;
            end
          end
          M_REMOVE, M_FAST_REM, M_CONTAINS: begin
            ptr_nxt = '0;
            if (empty) res_status_nxt = ST_MISSING;
          end
          M_REVERSE: begin
            ptr_nxt = '0;
            hi_nxt  = cnt_dec[AW-1:0];
          end
          M_CLEAR: cnt_nxt = '0;
          M_RESIZE: cnt_nxt = (idx_x < DEPTH_X) ? CW'(idx_x) : CNT_FULL;
          default: ;
        endcase
      end
      S_READ: begin
        res_value_nxt = VALUE_W'(ram_rdata);
        if (op_r == M_POP) cnt_nxt = cnt_dec;
      end
      S_INS_RD: begin
        alu_dec = 1'b1;
        if (ptr_r == CW'(idx_x)) begin
          ram_we    = 1'b1;
          ram_wdata = val_r;
          cnt_nxt   = cnt_r + CW'(1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = alu_y[AW-1:0];
        end
      end
      S_INS_WR: begin
        alu_dec = 1'b1;
        ram_we  = 1'b1;
        ptr_nxt = alu_y;
      end
      S_SRCH_RD: ram_re = 1'b1;
      S_SRCH_CMP: begin
        if (hit) begin
          if (op_r == M_FAST_REM) begin
            if (ptr_r == cnt_dec) begin
              cnt_nxt = cnt_dec;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = cnt_dec[AW-1:0];
            end
          end
        end else if (alu_y == cnt_r) begin
          res_status_nxt = ST_MISSING;
        end else begin
          ptr_nxt = alu_y;
        end
      end
      S_SHF_RD: begin
        if (alu_y >= cnt_r) begin
          cnt_nxt = cnt_dec;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = alu_y[AW-1:0];
        end
      end
      S_SHF_WR: begin
        ram_we  = 1'b1;
        ptr_nxt = alu_y;
      end
      S_FAST_WR: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_dec;
      end
      S_REV_RDLO: ram_re = 1'b1;
      S_REV_RDHI: begin
        tmp_nxt   = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = hi_r;
      end
      S_REV_WRLO: begin
        ram_we  = 1'b1;
        ptr_nxt = alu_y;
      end
      S_REV_WRHI: begin
        alu_hi    = 1'b1;
        alu_dec   = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = tmp_r;
        hi_nxt    = alu_y[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_r         <= hi_nxt;
    tmp_r        <= tmp_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    if (in_acc) begin
      op_r  <= mode_t'(in_bus.mode);
      val_r <= ITEM_WIDTH'(in_bus.value);
      idx_r <= in_bus.index;
    end
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_count_r  <= COUNT_W'(cnt_r);
    end
  end

  assign in_bus.ready         = (state_r == S_IDLE);
  assign out_bus.valid        = out_valid_r;
  assign out_bus.result_value = out_value_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.item_count   = out_count_r;

  `BLE_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_FULL, "fill count above capacity")
  `BLE_ASSERT(a_push_grows, clk, rst_n,
              (state_r == S_DISPATCH && op_r == M_PUSH && !full) |=>
              (cnt_r == $past(cnt_r) + CW'(1)),
              "push did not grow the count")
  `BLE_ASSERT(a_quiet_store, clk, rst_n,
              (state_r == S_IDLE || state_r == S_DONE) |-> !ram_we,
              "store written outside an operation")
  `BLE_ASSERT(a_out_from_done, clk, rst_n,
              $rose(out_valid_r) |-> $past(state_r) == S_DONE,
              "result beat raised outside the done step")

endmodule

/* verif/bounded_list_engine_unit_tb.sv */
// testbench of the bounded list engine: directed table, weighted random ops, scoreboard
module bounded_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ble_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int RANDOM_OPS  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 60;
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 4'd12;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 4'd15;

  typedef struct {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  typedef struct {
    logic [MODE_W-1:0]  op;
    logic [VALUE_W-1:0] word;
    logic [INDEX_W-1:0] pos;
    bit                 typed;
    logic [VALUE_W-1:0] exp_value;
    status_t            exp_status;
    logic [COUNT_W-1:0] exp_count;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ble_in_if  in_bus ();
  ble_out_if out_bus ();

  bounded_list_engine_unit #(
    .DEPTH      (LIST_DEPTH),
    .ITEM_WIDTH (VALUE_W)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // predicted list contents
  logic [VALUE_W-1:0] list_words [LIST_DEPTH];
  int unsigned        list_len;
  list_result_t       pending_results [$];
  int unsigned        mismatch_count;
  bit                 calm;
  bit                 hold_pending;

  // rows with typed expectations are checked as written, the rest use the predictor
  stim_row_t directed_rows [26] = '{
    '{M_POP,            32'h0,        5'd0,  1'b1, 32'h0,        ST_EMPTY,   5'd0},
    '{M_PEEK,           32'h0,        5'd0,  1'b1, 32'h0,        ST_EMPTY,   5'd0},
    '{M_GET,            32'h0,        5'd0,  1'b1, 32'h0,        ST_BADIDX,  5'd0},
    '{M_REMOVE,         32'h0,        5'd0,  1'b1, 32'h0,        ST_MISSING, 5'd0},
    '{M_FAST_REM,       32'h0,        5'd0,  1'b1, 32'h0,        ST_MISSING, 5'd0},
    '{M_CONTAINS,       32'h0,        5'd0,  1'b1, 32'h0,        ST_MISSING, 5'd0},
    '{M_REVERSE,        32'h0,        5'd0,  1'b1, 32'h0,        ST_OK,      5'd0},
    '{M_INSERT,         32'h1234,     5'd1,  1'b1, 32'h0,        ST_BADIDX,  5'd0},
    '{M_INSERT,         32'hFFFFFFFF, 5'd0,  1'b1, 32'h0,        ST_OK,      5'd1},
    '{M_PUSH,           32'h0,        5'd0,  1'b1, 32'h0,        ST_OK,      5'd2},
    '{M_PEEK,           32'h0,        5'd0,  1'b1, 32'h0,        ST_OK,      5'd2},
    '{M_GET,            32'h0,        5'd0,  1'b1, 32'hFFFFFFFF, ST_OK,      5'd2},
    '{M_SET,            32'hDEADBEEF, 5'd16, 1'b1, 32'h0,        ST_BADIDX,  5'd2},
    '{M_SET,            32'hA5A5A5A5, 5'd15, 1'b1, 32'h0,        ST_OK,      5'd16},
    '{M_PUSH,           32'h5A5A5A5A, 5'd0,  1'b1, 32'h0,        ST_FULL,    5'd16},
    '{M_INSERT,         32'h5A5A5A5A, 5'd31, 1'b1, 32'h0,        ST_FULL,    5'd16},
    '{M_GET,            32'h0,        5'd31, 1'b1, 32'h0,        ST_BADIDX,  5'd16},
    '{M_REVERSE,        32'h0,        5'd0,  1'b1, 32'h0,        ST_OK,      5'd16},
    '{M_GET,            32'h0,        5'd0,  1'b1, 32'hA5A5A5A5, ST_OK,      5'd16},
    '{M_FAST_REM,       32'hFFFFFFFF, 5'd0,  1'b0, 32'h0,        ST_OK,      5'd0},
    '{M_REMOVE,         32'h0,        5'd0,  1'b0, 32'h0,        ST_OK,      5'd0},
    '{M_POP,            32'h0,        5'd0,  1'b0, 32'h0,        ST_OK,      5'd0},
    '{M_RESIZE,         32'h0,        5'd31, 1'b1, 32'h0,        ST_OK,      5'd16},
    '{M_CLEAR,          32'h0,        5'd0,  1'b1, 32'h0,        ST_OK,      5'd0},
    '{MODE_SPARE_LAST,  32'hFFFFFFFF, 5'd31, 1'b1, 32'h0,        ST_OK,      5'd0},
    '{MODE_SPARE_FIRST, 32'h0,        5'd0,  1'b1, 32'h0,        ST_OK,      5'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // first position holding word, LIST_DEPTH when absent
  function automatic int unsigned locate_word(input logic [VALUE_W-1:0] word);
    for (int unsigned i = 0; i < list_len; i++)
      if (list_words[i] == word) return i;
    return LIST_DEPTH;
  endfunction

  function automatic list_result_t apply_list_op(input logic [MODE_W-1:0] op,
                                                 input logic [VALUE_W-1:0] word,
                                                 input logic [INDEX_W-1:0] pos);
    list_result_t       r;
    int unsigned        hit;
    int unsigned        lo;
    int unsigned        hi;
    logic [VALUE_W-1:0] tmp;
    r.value  = '0;
    r.status = ST_OK;
    case (op)
      M_PUSH: begin
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          list_words[list_len] = word;
          list_len++;
        end
      end
      M_POP, M_PEEK: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else begin
          r.value = list_words[list_len-1];
          if (op == M_POP) list_len--;
        end
      end
      M_GET: begin
        if (pos >= list_len) r.status = ST_BADIDX;
        else r.value = list_words[pos];
      end
      M_SET: begin
        if (pos >= LIST_DEPTH) r.status = ST_BADIDX;
        else begin
          list_words[pos] = word;
          if (pos + 1 > list_len) list_len = pos + 1;
        end
      end
      M_INSERT: begin
        if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else if (pos > list_len) r.status = ST_BADIDX;
        else begin
          for (int unsigned i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = word;
          list_len++;
        end
      end
      M_REMOVE: begin
        hit = locate_word(word);
        if (hit >= LIST_DEPTH) r.status = ST_MISSING;
        else begin
          for (int unsigned i = hit; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      M_FAST_REM: begin
        hit = locate_word(word);
        if (hit >= LIST_DEPTH) r.status = ST_MISSING;
        else begin
          list_words[hit] = list_words[list_len-1];
          list_len--;
        end
      end
      M_CONTAINS: begin
        if (locate_word(word) >= LIST_DEPTH) r.status = ST_MISSING;
      end
      M_REVERSE: begin
        if (list_len > 1) begin
          lo = 0;
          hi = list_len - 1;
          while (lo < hi) begin
            tmp            = list_words[lo];
            list_words[lo] = list_words[hi];
            list_words[hi] = tmp;
            lo++;
            hi--;
          end
        end
      end
      M_CLEAR:  list_len = 0;
      M_RESIZE: list_len = (pos < LIST_DEPTH) ? pos : LIST_DEPTH;
      default: ;
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  // offer one beat, wait for it to be taken, then record what must come back
  task automatic send_op(input stim_row_t row);
    list_result_t r;
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode  <= row.op;
    in_bus.value <= row.word;
    in_bus.index <= row.pos;
    do @(posedge clk); while (!in_bus.ready);
    r = apply_list_op(row.op, row.word, row.pos);
    if (row.typed) begin
      r.value  = row.exp_value;
      r.status = row.exp_status;
      r.count  = row.exp_count;
    end
    pending_results.push_back(r);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_bus.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_bus.ready <= calm || ($urandom_range(0, 99) >= 23);
      end
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, result_value", out_bus.result_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.result_value !== want.value)
          report_mismatch("result_value", out_bus.result_value, want.value);
        if (out_bus.status !== want.status)
          report_mismatch("status", VALUE_W'(out_bus.status), VALUE_W'(want.status));
        if (out_bus.item_count !== want.count)
          report_mismatch("item_count", VALUE_W'(out_bus.item_count), VALUE_W'(want.count));
      end
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] word_pool [8];
    stim_row_t          row;
    bit                 grow;
    int unsigned        pick;
    mismatch_count = 0;
    calm           = 1'b0;
    hold_pending   = 1'b0;
    list_len       = 0;
    for (int i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;
    rst_n        <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.mode  <= '0;
    in_bus.value <= '0;
    in_bus.index <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_op(directed_rows[i]);

    // small pool so searches and removes find matches often
    word_pool[0] = '0;
    word_pool[1] = '1;
    for (int i = 2; i < 8; i++) word_pool[i] = $urandom;
    grow = 1'b1;
    for (int k = 0; k < RANDOM_OPS; k++) begin
      if (k == 700) hold_pending = 1'b1;
      calm = (k >= 1200 && k < 1500);
      if (list_len >= LIST_DEPTH) grow = 1'b0;
      else if (list_len == 0) grow = 1'b1;
      else if ($urandom_range(0, 99) < 2) grow = !grow;

      pick = $urandom_range(0, 99);
      if (pick < 3) row.op = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      else if (pick < 5)  row.op = M_CLEAR;
      else if (pick < 9)  row.op = M_RESIZE;
      else if (pick < 13) row.op = M_REVERSE;
      else if (pick < 20) row.op = M_PEEK;
      else if (pick < 28) row.op = M_GET;
      else if (pick < 36) row.op = M_SET;
      else if (pick < 44) row.op = M_CONTAINS;
      else if (pick < 52) row.op = M_REMOVE;
      else if (pick < 60) row.op = M_FAST_REM;
      else if (pick < 80) row.op = grow ? M_PUSH : M_POP;
      else if (pick < 90) row.op = grow ? M_INSERT : M_POP;
      else row.op = grow ? M_INSERT : M_PUSH;

      if (list_len > 0 && $urandom_range(0, 1) == 1)
        row.word = list_words[$urandom_range(0, list_len - 1)];
      else if ($urandom_range(0, 99) < 70)
        row.word = word_pool[$urandom_range(0, 7)];
      else
        row.word = $urandom;

      if ($urandom_range(0, 99) < 80) row.pos = INDEX_W'($urandom_range(0, list_len));
      else row.pos = INDEX_W'($urandom_range(0, 31));

      row.typed      = 1'b0;
      row.exp_value  = '0;
      row.exp_status = ST_OK;
      row.exp_count  = '0;
      send_op(row);
    end
    in_bus.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
